[rtl/core/binomial_consecutive_prime_test_assert.svh]
// assertion macros for the binomial consecutive prime tester
`ifndef BINOMIAL_CONSECUTIVE_PRIME_TEST_ASSERT_SVH
`define BINOMIAL_CONSECUTIVE_PRIME_TEST_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BCPT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define BCPT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[rtl/core/bcpt_pkg.sv]
// shared types and constants for the binomial consecutive prime tester
package bcpt_pkg;
    localparam int NUM_W   = 32;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 17;
    localparam int DEPTH   = 65536;
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_NOT  = 2'd1;
    localparam logic [1:0] ST_PROD = 2'd2;
    localparam logic [1:0] ST_KGTN = 2'd3;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;
    localparam logic [0:0] REG_PRIME_COUNT = 1'b0;

    // request to the digit sum unit
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] base;
    } t_dsum_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W+1:0] sum;
    } t_dsum_rsp;
endpackage

[rtl/core/bcpt_divider.sv]
// restoring divider, one quotient bit per cycle
module bcpt_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bcpt_pkg::NUM_W-1:0] i_num,
    input  logic [bcpt_pkg::NUM_W-1:0] i_den,
    output logic                      o_done,
    output logic [bcpt_pkg::NUM_W-1:0] o_quo,
    output logic [bcpt_pkg::NUM_W-1:0] o_rem
);
    import bcpt_pkg::*;
    logic [NUM_W-1:0] r_q, r_den;
    logic [NUM_W:0]   r_r;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;
    logic [NUM_W:0]   n_sh;
    logic             n_ge;

    assign n_sh = {r_r[NUM_W-1:0], r_q[NUM_W-1]};
    assign n_ge = n_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_r    <= '0;
                r_cnt  <= 6'(NUM_W);
            end else if (r_busy) begin
                r_r   <= n_ge ? n_sh - {1'b0, r_den} : n_sh;
                r_q   <= {r_q[NUM_W-2:0], n_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r[NUM_W-1:0];
endmodule

[rtl/core/bcpt_digit_sum.sv]
// base-p digit sum, one digit per divider pass
module bcpt_digit_sum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcpt_pkg::t_dsum_req i_req,
    output bcpt_pkg::t_dsum_rsp o_rsp
);
    import bcpt_pkg::*;
    logic             r_busy, r_done, r_go;
    logic [NUM_W-1:0] r_v, r_base;
    logic [NUM_W+1:0] r_sum;
    logic             w_done;
    logic [NUM_W-1:0] w_q, w_r;

    bcpt_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go), .i_num(r_v),
        .i_den(r_base), .o_done(w_done), .o_quo(w_q), .o_rem(w_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_go   <= 1'b0;
            if (i_req.start) begin
                r_v    <= i_req.value;
                r_base <= i_req.base;
                r_sum  <= '0;
                if (i_req.value == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_go   <= 1'b1;
                end
            end else if (r_busy && w_done) begin
                r_sum <= r_sum + (NUM_W+2)'(w_r);
                r_v   <= w_q;
                if (w_q == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_go <= 1'b1;
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.sum  = r_sum;
endmodule

[rtl/core/binomial_consecutive_prime_test.sv]
// Binomial consecutive prime tester. A load transaction writes one table entry;
// its result passes through the output state into the output register. A test
// transaction with k above n is answered without a walk; any other walks table
// entries from index 0 while below prime_count, capped at the table depth, and
// not above n. Each visited entry is read from the table and checked; an entry
// of 2 or more also takes three base-p digit sums, one after another, on one
// shared bit-serial divider.
// One transaction is in work at a time; the result waits in an output register.
module binomial_consecutive_prime_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: entry_index[15:0], prime_value[47:16], n_value[79:48], k_value[111:80]
    input  logic [111:0] s_axis_tdata,
    // tuser: opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], first_index[17:2], last_index[33:18], run_length[50:34]
    output logic [55:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcpt_pkg::*;
`include "binomial_consecutive_prime_test_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_DK, S_DNK, S_DN, S_EVAL, S_OUT
    } t_state;

    t_state           r_state;
    logic [NUM_W-1:0] prime_mem [DEPTH];
    logic [NUM_W-1:0] r_rd, r_n, r_k, r_p;
    logic [CNT_W-1:0] r_cnt, r_i, r_lo, r_hi;
    logic             r_have, r_ok;
    logic [NUM_W+1:0] r_sk, r_snk;
    logic             r_ovalid;
    logic [55:0]      r_odata;
    t_dsum_req        r_req;
    t_dsum_rsp        w_rsp;
    logic [NUM_W+1:0] n_car;
    logic             n_e1, n_e2;
    logic [CNT_W-1:0] w_lim;

    bcpt_digit_sum u_dsum (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    assign pready        = 1'b1;
    assign prdata        = {15'd0, r_cnt};
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign w_lim         = (r_cnt > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cnt;
    assign n_car         = r_sk + r_snk - w_rsp.sum;
    assign n_e2          = n_car >= {r_p - 32'd1, 1'b0};
    assign n_e1          = !n_e2 && (n_car >= {2'b00, r_p - 32'd1});

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD)
            prime_mem[s_axis_tdata[IDX_W-1:0]] <= s_axis_tdata[47:16];
        r_rd <= prime_mem[r_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == REG_PRIME_COUNT)
                r_cnt <= pwdata[CNT_W-1:0];
            if (r_ovalid && m_axis_tready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_n <= s_axis_tdata[79:48];
                        r_k <= s_axis_tdata[111:80];
                        r_i <= '0;
                        r_have <= 1'b0;
                        r_ok <= 1'b1;
                        if (s_axis_tuser == OP_LOAD) begin
                            r_odata <= {54'd0, ST_LOAD};
                            r_state <= S_OUT;
                        end else if (s_axis_tdata[111:80] > s_axis_tdata[79:48]) begin
                            r_odata <= {54'd0, ST_KGTN};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (!r_ok || r_i >= w_lim) r_state <= S_EVAL;
                    else r_state <= S_CHK;
                end
                S_CHK: begin
                    r_p <= r_rd;
                    if (r_rd > r_n) begin
                        r_state <= S_EVAL;
                    end else if (r_rd < 32'd2) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.value <= r_k;
                        r_req.base  <= r_rd;
                        r_state <= S_DK;
                    end
                end
                S_DK: if (w_rsp.done) begin
                    r_sk <= w_rsp.sum;
                    r_req.start <= 1'b1;
                    r_req.value <= r_n - r_k;
                    r_state <= S_DNK;
                end
                S_DNK: if (w_rsp.done) begin
                    r_snk <= w_rsp.sum;
                    r_req.start <= 1'b1;
                    r_req.value <= r_n;
                    r_state <= S_DN;
                end
                S_DN: if (w_rsp.done) begin
                    if (n_e2) begin
                        r_ok <= 1'b0;
                    end else if (n_e1) begin
                        if (!r_have) begin
                            r_have <= 1'b1;
                            r_lo <= r_i;
                            r_hi <= r_i;
                        end else if (r_i == r_hi + 1'b1) begin
                            r_hi <= r_i;
                        end else begin
                            r_ok <= 1'b0;
                        end
                    end
                    r_i <= r_i + 1'b1;
                    r_state <= S_RD;
                end
                S_EVAL: begin
                    if (r_ok && r_have)
                        r_odata <= {5'd0, CNT_W'(r_hi - r_lo + 1'b1),
                                    r_hi[IDX_W-1:0], r_lo[IDX_W-1:0], ST_PROD};
                    else
                        r_odata <= {54'd0, ST_NOT};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BCPT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `BCPT_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, r_ovalid)
    `BCPT_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == S_CHK, r_i < w_lim)
endmodule

[tb/sv/tb_binomial_consecutive_prime_test.sv]
// testbench for the binomial consecutive prime tester: table loads and n,k tests
`timescale 1ns / 1ps
module tb_binomial_consecutive_prime_test;
    import bcpt_pkg::*;

    typedef struct packed {
        logic [16:0] run_length;
        logic [15:0] last_index;
        logic [15:0] first_index;
        logic [1:0]  status;
    } t_verdict;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    binomial_consecutive_prime_test dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block state
    logic [31:0] shadow_table [0:DEPTH-1];
    logic [16:0] shadow_count;
    int          loaded_entries;
    t_verdict    pending_verdicts [$];
    int          errors;
    int          idle_cycles;
    bit          quiet_mode;
    bit          hold_sink;
    int          hold_cycles;
    int          small_primes [0:15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                         43, 47, 53};

    function automatic longint unsigned base_digit_sum(longint unsigned v,
                                                       longint unsigned b);
        longint unsigned s;
        s = 0;
        while (v != 0) begin
            s += v % b;
            v /= b;
        end
        return s;
    endfunction

    function automatic t_verdict judge_item(logic op, logic [15:0] idx, logic [31:0] pv,
                                            logic [31:0] nv, logic [31:0] kv);
        t_verdict        r;
        longint unsigned n, k, p, e, lo, hi, lim;
        bit              have, ok;
        r = '0;
        if (op == OP_LOAD) begin
            shadow_table[idx] = pv;
            r.status = ST_LOAD;
            return r;
        end
        n = nv;
        k = kv;
        if (k > n) begin
            r.status = ST_KGTN;
            return r;
        end
        lim = (shadow_count > DEPTH) ? DEPTH : shadow_count;
        have = 0;
        ok = 1;
        lo = 0;
        hi = 0;
        for (longint unsigned i = 0; i < lim && ok; i++) begin
            p = shadow_table[i];
            if (p > n) break;
            if (p < 2) continue;
            e = (base_digit_sum(k, p) + base_digit_sum(n - k, p)
                 - base_digit_sum(n, p)) / (p - 1);
            if (e >= 2) ok = 0;
            else if (e == 1) begin
                if (!have) begin
                    have = 1;
                    lo = i;
                    hi = i;
                end else if (i == hi + 1) hi = i;
                else ok = 0;
            end
        end
        if (ok && have) begin
            r.status = ST_PROD;
            r.first_index = lo[15:0];
            r.last_index = hi[15:0];
            r.run_length = 17'(hi - lo + 1);
        end else begin
            r.status = ST_NOT;
        end
        return r;
    endfunction

    task automatic send_item(logic op, logic [15:0] idx, logic [31:0] pv,
                             logic [31:0] nv, logic [31:0] kv);
        if (!quiet_mode && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (!quiet_mode && $urandom_range(99) < 8) @(posedge i_clk);
        end
        pending_verdicts.push_back(judge_item(op, idx, pv, nv, kv));
        if (op == OP_LOAD && idx >= loaded_entries) loaded_entries = idx + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {kv, nv, pv, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_prime_count(logic [16:0] value);
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_PRIME_COUNT, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_count = value;
    endtask

    // send a test transaction for n and k; index and prime fields are zero
    task automatic send_test(logic [31:0] nv, logic [31:0] kv);
        send_item(OP_TEST, 16'd0, 32'd0, nv, kv);
    endtask

    task automatic test_load_table();
        for (int i = 0; i < 16; i++) send_item(OP_LOAD, 16'(i), small_primes[i], 0, 0);
        loaded_entries = 16;
        send_item(OP_LOAD, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_LOAD, 16'hfffe, 32'h0000_0000, 32'h0, 32'h0);
    endtask

    task automatic test_directed();
        write_prime_count(17'd0);
        send_test(32'd10, 32'd3);
        write_prime_count(17'd16);
        send_test(32'd0, 32'd0);
        send_test(32'd5, 32'd0);
        send_test(32'd5, 32'd5);
        send_test(32'd3, 32'd4);
        send_test(32'd0, 32'hffff_ffff);
        send_test(32'd6, 32'd3);
        send_test(32'd7, 32'd2);
        send_test(32'd10, 32'd1);
        send_test(32'd8, 32'd4);
        send_test(32'd30, 32'd15);
        send_test(32'hffff_ffff, 32'hffff_ffff);
        send_test(32'hffff_ffff, 32'd1);
        send_test(32'd31, 32'd1);
        // entry below two opens a gap
        send_item(OP_LOAD, 16'd1, 32'd1, 0, 0);
        send_test(32'd6, 32'd1);
        send_item(OP_LOAD, 16'd1, 32'd0, 0, 0);
        send_test(32'd6, 32'd1);
        send_item(OP_LOAD, 16'd1, 32'd3, 0, 0);
        write_prime_count(17'h1ffff);
        send_test(32'd40, 32'd2);
        write_prime_count(17'd16);
    endtask

    task automatic test_random();
        logic [31:0] n, k;
        for (int i = 0; i < 80; i++) begin
            quiet_mode = (i >= 40 && i < 70);
            if ($urandom_range(9) == 0) begin
                send_item(OP_LOAD, 16'($urandom_range(15)), small_primes[$urandom_range(15)],
                          $urandom, $urandom);
            end else begin
                n = (i % 17 == 0) ? $urandom : $urandom_range(60);
                k = ($urandom_range(7) == 0) ? $urandom : $urandom_range(n);
                send_test(n, k);
            end
            if (i % 35 == 34) write_prime_count(17'($urandom_range(16)));
        end
        quiet_mode = 0;
        drain_results();
        for (int i = 0; i < 16; i++) send_item(OP_LOAD, 16'(i), small_primes[i], 0, 0);
    endtask

    task automatic test_back_pressure();
        write_prime_count(17'd16);
        hold_cycles = 300;
        hold_sink = 1;
        for (int i = 0; i < 6; i++) send_test(32'($urandom_range(40)), 32'd1);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (hold_sink) begin
            m_axis_tready <= 1'b0;
            if (hold_cycles == 0) hold_sink <= 0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            m_axis_tready <= quiet_mode || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[50:0];
            if (pending_verdicts.size() == 0) begin
                $display("%0t unexpected transaction: expected none actual %h", $time, got);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status != want.status || got.first_index != want.first_index ||
                    got.last_index != want.last_index || got.run_length != want.run_length) begin
                    $display("%0t mismatch: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                             $time, want.status, want.first_index, want.last_index,
                             want.run_length, got.status, got.first_index, got.last_index,
                             got.run_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("binomial_consecutive_prime_test regression: fail");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        quiet_mode = 0;
        hold_sink = 0;
        hold_cycles = 0;
        shadow_count = 0;
        loaded_entries = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_table();
        test_directed();
        test_random();
        test_back_pressure();
        drain_results();
        if (errors == 0) $display("binomial_consecutive_prime_test regression: pass");
        else $display("binomial_consecutive_prime_test regression: fail");
        $finish;
    end
endmodule
